// ===== src/lfps_pkg.sv =====
`default_nettype none
package lfps_pkg;

	localparam int GAIN_W     = 12;
	localparam int ERR_W      = 16;
	localparam int DERR_W     = 17;
	localparam int ACC_W      = 30;
	localparam int NUM_W      = 33;
	localparam int CORR_SHIFT = 16;
	localparam int CORR_W     = NUM_W - CORR_SHIFT;
	localparam int DSUM_W     = 19;
	localparam int DUTY_W     = 16;
	localparam int MODE_W     = 2;
	localparam int TURN_W     = 13;
	localparam int LOST_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PCT_Q8     = 25600;
	localparam int GAIN_MULT  = 7;
	localparam int PEAK_RESET = 3000;
	localparam int ERR_MAX    = 25600;

	localparam int BASE_SPEED_RST = 2500;
	localparam int KP_GAIN_RST    = 486;
	localparam int KD_GAIN_RST    = 717;
	localparam int TURN_THR_RST   = 500;
	localparam int LOST_THR_RST   = 50;
	localparam int DUTY_LIMIT_RST = 7000;
	localparam int DUTY_FLOOR_RST = 1400;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_SPEED     = 3'd0,
		CFG_KP_GAIN        = 3'd1,
		CFG_KD_GAIN        = 3'd2,
		CFG_TURN_THRESHOLD = 3'd3,
		CFG_LOST_THRESHOLD = 3'd4,
		CFG_DUTY_LIMIT     = 3'd5,
		CFG_DUTY_FLOOR     = 3'd6
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SHARP = 2'd0,
		MODE_TRACK = 2'd1,
		MODE_LOST  = 2'd2
	} drive_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NA_GO,
		ST_NA_WAIT,
		ST_NB_GO,
		ST_NB_WAIT,
		ST_ER_SETUP,
		ST_ER_GO,
		ST_ER_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_SCALE,
		ST_DONE
	} lfps_state_t;

endpackage
`default_nettype wire

// ===== src/lfps_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lfps_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CNT_W'(DVD_W))
		else $error("divider did not load");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && dvs_q != '0) |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// ===== src/lfps_pdmul.sv =====
`default_nettype none
// Bit-serial shift-add: err*kp + derr*kd, one gain bit per cycle.
module lfps_pdmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lfps_pkg::ERR_W-1:0]   err,
	input  logic signed [lfps_pkg::DERR_W-1:0]  derr,
	input  logic [lfps_pkg::GAIN_W-1:0]         kp,
	input  logic [lfps_pkg::GAIN_W-1:0]         kd,
	output logic                                done,
	output logic signed [lfps_pkg::ACC_W-1:0]   product
);
	import lfps_pkg::*;

	localparam int MCNT_W = $clog2(GAIN_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [MCNT_W-1:0] cnt_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] kd_q;
	logic signed [ACC_W-1:0] e_q;
	logic signed [ACC_W-1:0] d_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] add_e;
	logic signed [ACC_W-1:0] add_d;

	assign add_e = kp_q[0] ? e_q : '0;
	assign add_d = kd_q[0] ? d_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MCNT_W'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q   <= ACC_W'(err);
			d_q   <= ACC_W'(derr);
			kp_q  <= kp;
			kd_q  <= kd;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + add_e + add_d;
			e_q   <= e_q <<< 1;
			d_q   <= d_q <<< 1;
			kp_q  <= kp_q >> 1;
			kd_q  <= kd_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

// ===== src/line_follow_pd_steering.sv =====
// PD steering for an inductive line follower.
// Sample channel: sample_valid/sample_ready with five raw coil samples and five
// filtered averages. Taken only while the block is idle; sample_ready is high then.
// Duty channel: duty_valid/duty_ready with left_duty, right_duty and drive_mode
// (0 sharp turn, 1 tracking, 2 line lost). One result word per sample word.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// base_speed, kp_gain, kd_gain, turn_threshold, lost_threshold, duty_limit,
// duty_floor (0..6); other indexes are ignored. Write only while idle.
// The three bit-serial divides (two normalizations, one difference-over-sum) run
// on the one shared restoring divider, followed by the serial PD multiply; the
// difference-over-sum divide is skipped when both normalized side channels are
// zero. The next sample is taken in the cycle after the result enters the output
// register, even while that word still waits.
// If the receiver stalls, the finished word holds in the output register and
// the next item stops at its last step until the register frees.
// Reset: registers take their documented defaults, channel peaks go to 3000,
// the stored error clears, no word is pending.
`default_nettype none
module line_follow_pd_steering #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [SAMPLE_BITS-1:0]              raw_far_left,
	input  logic [SAMPLE_BITS-1:0]              raw_inner_left,
	input  logic [SAMPLE_BITS-1:0]              raw_middle,
	input  logic [SAMPLE_BITS-1:0]              raw_inner_right,
	input  logic [SAMPLE_BITS-1:0]              raw_far_right,
	input  logic [SAMPLE_BITS-1:0]              avg_far_left,
	input  logic [SAMPLE_BITS-1:0]              avg_inner_left,
	input  logic [SAMPLE_BITS-1:0]              avg_middle,
	input  logic [SAMPLE_BITS-1:0]              avg_inner_right,
	input  logic [SAMPLE_BITS-1:0]              avg_far_right,
	output logic                                duty_valid,
	input  logic                                duty_ready,
	output logic [lfps_pkg::DUTY_W-1:0]         left_duty,
	output logic [lfps_pkg::DUTY_W-1:0]         right_duty,
	output logic [lfps_pkg::MODE_W-1:0]         drive_mode,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lfps_pkg::*;

	localparam int PEAK_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
	localparam int TSUM_W = (SAMPLE_BITS + 1 > TURN_W) ? SAMPLE_BITS + 1 : TURN_W;
	localparam int NORM_W = SAMPLE_BITS + 4;
	localparam int DVD_W  = NORM_W + 15;
	localparam int DVS_W  = NORM_W + 1;
	localparam int NCH    = 5;

	// config
	logic [DUTY_W-1:0] base_speed_q;
	logic [GAIN_W-1:0] kp_gain_q;
	logic [GAIN_W-1:0] kd_gain_q;
	logic [TURN_W-1:0] turn_thr_q;
	logic [LOST_W-1:0] lost_thr_q;
	logic [DUTY_W-1:0] duty_limit_q;
	logic [DUTY_W-1:0] duty_floor_q;

	lfps_state_t state_q, state_nx;

	logic [PEAK_W-1:0]      peak_q [NCH];
	logic [PEAK_W-1:0]      peak_nx [NCH];
	logic [SAMPLE_BITS-1:0] raw_v [NCH];

	logic sample_acc;
	logic sharp;
	logic lost;
	logic out_free;

	drive_mode_t            mode_q;
	logic [SAMPLE_BITS-1:0] avg_a_q;
	logic [SAMPLE_BITS-1:0] avg_b_q;
	logic [PEAK_W-1:0]      peak_a_q;
	logic [PEAK_W-1:0]      peak_b_q;
	logic [NORM_W-1:0]      norm_a_q;
	logic [NORM_W-1:0]      norm_b_q;
	logic [DVD_W-1:0]       err_dvd_q;
	logic [DVS_W-1:0]       err_dvs_q;
	logic                   err_neg_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [CORR_W-1:0] corr_q;

	logic                   norm_zero;
	logic                   norm_neg;
	logic [NORM_W-1:0]      norm_mag;
	logic [ERR_W-1:0]       quot_err;
	logic signed [DERR_W-1:0] derr;
	logic signed [NUM_W-1:0]  num_adj;
	logic signed [DSUM_W-1:0] base_s;
	logic signed [DSUM_W-1:0] corr_s;
	logic signed [DSUM_W-1:0] sum_l;
	logic signed [DSUM_W-1:0] sum_r;
	logic [DUTY_W-1:0]        left_nx;
	logic [DUTY_W-1:0]        right_nx;

	logic              div_start;
	logic              div_done;
	logic [DVD_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic [DVD_W-1:0]  div_quot;
	logic              mul_start;
	logic              mul_done;
	logic signed [ACC_W-1:0] mul_prod;

	logic              duty_valid_q;
	logic [DUTY_W-1:0] left_duty_q;
	logic [DUTY_W-1:0] right_duty_q;
	drive_mode_t       drive_mode_q;

	function automatic logic [DUTY_W-1:0] sat_top(input logic signed [DSUM_W-1:0] v,
			input logic [DUTY_W-1:0] limit);
		logic signed [DSUM_W-1:0] lim_s;
		lim_s = $signed({{(DSUM_W-DUTY_W){1'b0}}, limit});
		if (v < 0)
			return '0;
		else if (v > lim_s)
			return limit;
		else
			return v[DUTY_W-1:0];
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_db(input logic signed [DSUM_W-1:0] v,
			input logic [DUTY_W-1:0] limit, input logic [DUTY_W-1:0] floor_v);
		logic signed [DSUM_W-1:0] lim_s;
		logic signed [DSUM_W-1:0] flr_s;
		lim_s = $signed({{(DSUM_W-DUTY_W){1'b0}}, limit});
		flr_s = $signed({{(DSUM_W-DUTY_W){1'b0}}, floor_v});
		if (v > lim_s)
			return limit;
		else if (v < flr_s || v < 0)
			return '0;
		else
			return v[DUTY_W-1:0];
	endfunction

	assign cfg_ready  = 1'b1;
	assign sample_acc = sample_valid && sample_ready;
	assign out_free   = !duty_valid_q || duty_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= DUTY_W'(BASE_SPEED_RST);
			kp_gain_q    <= GAIN_W'(KP_GAIN_RST);
			kd_gain_q    <= GAIN_W'(KD_GAIN_RST);
			turn_thr_q   <= TURN_W'(TURN_THR_RST);
			lost_thr_q   <= LOST_W'(LOST_THR_RST);
			duty_limit_q <= DUTY_W'(DUTY_LIMIT_RST);
			duty_floor_q <= DUTY_W'(DUTY_FLOOR_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BASE_SPEED:     base_speed_q <= cfg_data;
				CFG_KP_GAIN:        kp_gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_KD_GAIN:        kd_gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_TURN_THRESHOLD: turn_thr_q   <= cfg_data[TURN_W-1:0];
				CFG_LOST_THRESHOLD: lost_thr_q   <= cfg_data[LOST_W-1:0];
				CFG_DUTY_LIMIT:     duty_limit_q <= cfg_data;
				CFG_DUTY_FLOOR:     duty_floor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign raw_v[0] = raw_far_left;
	assign raw_v[1] = raw_inner_left;
	assign raw_v[2] = raw_middle;
	assign raw_v[3] = raw_inner_right;
	assign raw_v[4] = raw_far_right;

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			peak_nx[i] = (PEAK_W'(raw_v[i]) > peak_q[i]) ? PEAK_W'(raw_v[i]) : peak_q[i];
		end
	end

	assign sharp = (TSUM_W'(raw_inner_left) + TSUM_W'(raw_inner_right)) >= TSUM_W'(turn_thr_q);
	assign lost  = PEAK_W'(raw_middle) < PEAK_W'(lost_thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				peak_q[i] <= PEAK_W'(PEAK_RESET);
			end
		end else if (sample_acc) begin
			for (int i = 0; i < NCH; i++) begin
				peak_q[i] <= peak_nx[i];
			end
		end
	end

	// error stage helpers
	assign norm_zero = (norm_a_q == '0) && (norm_b_q == '0);
	assign norm_neg  = norm_b_q < norm_a_q;
	assign norm_mag  = norm_neg ? (norm_a_q - norm_b_q) : (norm_b_q - norm_a_q);
	assign quot_err  = div_quot[ERR_W-1:0];
	assign derr      = DERR_W'(err_q) - DERR_W'(prev_err_q);

	// truncate toward zero on the divide by 2^16
	assign num_adj = num_q[NUM_W-1] ? (num_q + NUM_W'((1 << CORR_SHIFT) - 1)) : num_q;

	assign base_s = $signed({{(DSUM_W-DUTY_W){1'b0}}, base_speed_q});
	assign corr_s = DSUM_W'(corr_q);
	assign sum_l  = base_s + corr_s;
	assign sum_r  = base_s - corr_s;

	always_comb begin
		left_nx  = '0;
		right_nx = '0;
		unique case (mode_q)
			MODE_SHARP: begin
				if (err_q > 0)
					left_nx = sat_top(sum_l, duty_limit_q);
				else
					right_nx = sat_top(sum_r, duty_limit_q);
			end
			MODE_TRACK: begin
				left_nx  = clamp_db(sum_l, duty_limit_q, duty_floor_q);
				right_nx = clamp_db(sum_r, duty_limit_q, duty_floor_q);
			end
			MODE_LOST: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sample_acc) begin
			mode_q   <= sharp ? MODE_SHARP : (lost ? MODE_LOST : MODE_TRACK);
			avg_a_q  <= sharp ? avg_inner_left : avg_far_left;
			avg_b_q  <= sharp ? avg_inner_right : avg_far_right;
			peak_a_q <= sharp ? peak_nx[1] : peak_nx[0];
			peak_b_q <= sharp ? peak_nx[3] : peak_nx[4];
		end
		if (state_q == ST_NA_WAIT && div_done)
			norm_a_q <= div_quot[NORM_W-1:0];
		if (state_q == ST_NB_WAIT && div_done)
			norm_b_q <= div_quot[NORM_W-1:0];
		if (state_q == ST_ER_SETUP) begin
			err_dvd_q <= DVD_W'(norm_mag) * DVD_W'(PCT_Q8);
			err_dvs_q <= DVS_W'(norm_a_q) + DVS_W'(norm_b_q);
			err_neg_q <= norm_neg;
			if (norm_zero)
				err_q <= '0;
		end
		if (state_q == ST_ER_WAIT && div_done)
			err_q <= err_neg_q ? -$signed(quot_err) : $signed(quot_err);
		if (state_q == ST_MUL_WAIT && mul_done)
			num_q <= NUM_W'(mul_prod) * NUM_W'(GAIN_MULT);
		if (state_q == ST_SCALE)
			corr_q <= num_adj[NUM_W-1:CORR_SHIFT];
		if (state_q == ST_DONE && out_free) begin
			left_duty_q  <= left_nx;
			right_duty_q <= right_nx;
			drive_mode_q <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_err_q   <= '0;
			duty_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SCALE)
				prev_err_q <= err_q;
			if (state_q == ST_DONE && out_free)
				duty_valid_q <= 1'b1;
			else if (duty_ready)
				duty_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (sample_valid) state_nx = ST_NA_GO;
			ST_NA_GO:    state_nx = ST_NA_WAIT;
			ST_NA_WAIT:  if (div_done) state_nx = ST_NB_GO;
			ST_NB_GO:    state_nx = ST_NB_WAIT;
			ST_NB_WAIT:  if (div_done) state_nx = ST_ER_SETUP;
			ST_ER_SETUP: state_nx = norm_zero ? ST_MUL_GO : ST_ER_GO;
			ST_ER_GO:    state_nx = ST_ER_WAIT;
			ST_ER_WAIT:  if (div_done) state_nx = ST_MUL_GO;
			ST_MUL_GO:   state_nx = ST_MUL_WAIT;
			ST_MUL_WAIT: if (mul_done) state_nx = ST_SCALE;
			ST_SCALE:    state_nx = ST_DONE;
			ST_DONE:     if (out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		mul_start    = 1'b0;
		unique case (state_q)
			ST_IDLE: sample_ready = 1'b1;
			ST_NA_GO: begin
				div_start    = 1'b1;
				div_dividend = DVD_W'(avg_a_q) * DVD_W'(PCT_Q8);
				div_divisor  = DVS_W'(peak_a_q);
			end
			ST_NB_GO: begin
				div_start    = 1'b1;
				div_dividend = DVD_W'(avg_b_q) * DVD_W'(PCT_Q8);
				div_divisor  = DVS_W'(peak_b_q);
			end
			ST_ER_GO: begin
				div_start    = 1'b1;
				div_dividend = err_dvd_q;
				div_divisor  = err_dvs_q;
			end
			ST_MUL_GO: mul_start = 1'b1;
			default: ;
		endcase
	end

	lfps_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	lfps_pdmul u_pdmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.err     (err_q),
		.derr    (derr),
		.kp      (kp_gain_q),
		.kd      (kd_gain_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign duty_valid = duty_valid_q;
	assign left_duty  = left_duty_q;
	assign right_duty = right_duty_q;
	assign drive_mode = drive_mode_q;

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_GO) |-> (err_q <= ERR_MAX && err_q >= -ERR_MAX))
		else $error("steering error out of range");

	a_lost_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(duty_valid && drive_mode == MODE_LOST) |-> (left_duty == '0 && right_duty == '0))
		else $error("wheels driven with line lost");

	a_duty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid |-> (left_duty <= duty_limit_q && right_duty <= duty_limit_q &&
			(drive_mode != MODE_SHARP || left_duty == '0 || right_duty == '0)))
		else $error("duty above limit or both wheels driven in sharp turn");

endmodule
`default_nettype wire

// ===== sim/duty_checker.sv =====
module duty_checker
	import lfps_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] raw_far_left,
	input  logic [SAMPLE_BITS-1:0] raw_inner_left,
	input  logic [SAMPLE_BITS-1:0] raw_middle,
	input  logic [SAMPLE_BITS-1:0] raw_inner_right,
	input  logic [SAMPLE_BITS-1:0] raw_far_right,
	input  logic [SAMPLE_BITS-1:0] avg_far_left,
	input  logic [SAMPLE_BITS-1:0] avg_inner_left,
	input  logic [SAMPLE_BITS-1:0] avg_middle,
	input  logic [SAMPLE_BITS-1:0] avg_inner_right,
	input  logic [SAMPLE_BITS-1:0] avg_far_right,
	input  logic                   duty_valid,
	input  logic                   duty_ready,
	input  logic [DUTY_W-1:0]      left_duty,
	input  logic [DUTY_W-1:0]      right_duty,
	input  logic [MODE_W-1:0]      drive_mode,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     owed
);

	typedef struct packed {
		logic [DUTY_W-1:0] left;
		logic [DUTY_W-1:0] right;
		drive_mode_t       mode;
	} duty_word_t;

	logic [DUTY_W-1:0]       base_speed, duty_limit, duty_floor;
	logic [GAIN_W-1:0]       kp_gain, kd_gain;
	logic [TURN_W-1:0]       turn_thr;
	logic [LOST_W-1:0]       lost_thr;
	logic [SAMPLE_BITS-1:0]  peak [5];
	logic signed [ERR_W-1:0] last_err;
	duty_word_t              owed_duties [$];

	// driven wheel in a sharp turn: no deadband
	function automatic logic [DUTY_W-1:0] sat_driven(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(duty_limit))
			return duty_limit;
		return DUTY_W'(v);
	endfunction

	function automatic logic [DUTY_W-1:0] sat_tracked(longint v);
		if (v > longint'(duty_limit))
			return duty_limit;
		if (v < longint'(duty_floor) || v < 0)
			return '0;
		return DUTY_W'(v);
	endfunction

	// difference over sum, Q8 percent, truncated toward zero
	function automatic longint steer_error(longint a, longint b);
		if (a + b == 0)
			return 0;
		return ((b - a) * PCT_Q8) / (a + b);
	endfunction

	task automatic flag(input string why, input duty_word_t want, input duty_word_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: duty word %s: expected %0d/%0d mode %0d, got %0d/%0d mode %0d",
				$time, why, want.left, want.right, want.mode,
				got.left, got.right, got.mode);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic [SAMPLE_BITS-1:0] raw [5];
		logic [SAMPLE_BITS-1:0] avg [5];
		longint norm [5];
		longint err, corr;
		duty_word_t want, got;
		if (!arst_n) begin
			base_speed = DUTY_W'(BASE_SPEED_RST);
			kp_gain    = GAIN_W'(KP_GAIN_RST);
			kd_gain    = GAIN_W'(KD_GAIN_RST);
			turn_thr   = TURN_W'(TURN_THR_RST);
			lost_thr   = LOST_W'(LOST_THR_RST);
			duty_limit = DUTY_W'(DUTY_LIMIT_RST);
			duty_floor = DUTY_W'(DUTY_FLOOR_RST);
			foreach (peak[i])
				peak[i] = SAMPLE_BITS'(PEAK_RESET);
			last_err = '0;
			owed_duties.delete();
		end else begin
			// the result word leaving at this edge belongs to an earlier sample
			if (duty_valid && duty_ready) begin
				got.left  = left_duty;
				got.right = right_duty;
				got.mode  = drive_mode_t'(drive_mode);
				if (owed_duties.size() == 0) begin
					want = '0;
					flag("with none owed", want, got);
				end else begin
					want = owed_duties.pop_front();
					if (got.left !== want.left || got.right !== want.right
						|| got.mode !== want.mode)
						flag("mismatch", want, got);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BASE_SPEED:     base_speed = cfg_data;
					CFG_KP_GAIN:        kp_gain    = cfg_data[GAIN_W-1:0];
					CFG_KD_GAIN:        kd_gain    = cfg_data[GAIN_W-1:0];
					CFG_TURN_THRESHOLD: turn_thr   = cfg_data[TURN_W-1:0];
					CFG_LOST_THRESHOLD: lost_thr   = cfg_data[LOST_W-1:0];
					CFG_DUTY_LIMIT:     duty_limit = cfg_data;
					CFG_DUTY_FLOOR:     duty_floor = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) begin
				raw[0] = raw_far_left;
				raw[1] = raw_inner_left;
				raw[2] = raw_middle;
				raw[3] = raw_inner_right;
				raw[4] = raw_far_right;
				avg[0] = avg_far_left;
				avg[1] = avg_inner_left;
				avg[2] = avg_middle;
				avg[3] = avg_inner_right;
				avg[4] = avg_far_right;
				for (int i = 0; i < 5; i++) begin
					if (raw[i] > peak[i])
						peak[i] = raw[i];
					norm[i] = longint'(avg[i]) * PCT_Q8 / longint'(peak[i]);
				end
				want = '0;
				if (longint'(raw[1]) + longint'(raw[3]) >= longint'(turn_thr)) begin
					want.mode = MODE_SHARP;
					err = steer_error(norm[1], norm[3]);
				end else begin
					want.mode = (raw[2] >= lost_thr) ? MODE_TRACK : MODE_LOST;
					err = steer_error(norm[0], norm[4]);
				end
				corr = (GAIN_MULT * (err * longint'(kp_gain)
					+ (err - longint'(last_err)) * longint'(kd_gain))) / 65536;
				case (want.mode)
					MODE_SHARP: begin
						if (err > 0)
							want.left = sat_driven(longint'(base_speed) + corr);
						else
							want.right = sat_driven(longint'(base_speed) - corr);
					end
					MODE_TRACK: begin
						want.left  = sat_tracked(longint'(base_speed) + corr);
						want.right = sat_tracked(longint'(base_speed) - corr);
					end
					default: ;
				endcase
				// error memory updates in every mode, line lost included
				last_err = ERR_W'(err);
				owed_duties.push_back(want);
			end
		end
		owed = owed_duties.size();
	end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import lfps_pkg::*;

	localparam int SB           = 12;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 3 * SB + 81 + 40;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 100;
	// unused register slot, ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic [SB-1:0]         raw_far_left = '0;
	logic [SB-1:0]         raw_inner_left = '0;
	logic [SB-1:0]         raw_middle = '0;
	logic [SB-1:0]         raw_inner_right = '0;
	logic [SB-1:0]         raw_far_right = '0;
	logic [SB-1:0]         avg_far_left = '0;
	logic [SB-1:0]         avg_inner_left = '0;
	logic [SB-1:0]         avg_middle = '0;
	logic [SB-1:0]         avg_inner_right = '0;
	logic [SB-1:0]         avg_far_right = '0;
	logic                  duty_valid;
	logic                  duty_ready = 1'b0;
	logic [DUTY_W-1:0]     left_duty;
	logic [DUTY_W-1:0]     right_duty;
	logic [MODE_W-1:0]     drive_mode;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet = 0;
	int turn_thr = TURN_THR_RST;
	int lost_thr = LOST_THR_RST;

	line_follow_pd_steering #(.SAMPLE_BITS(SB)) dut (.*);

	duty_checker #(.SAMPLE_BITS(SB)) chk (.*, .errors(fail_count));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		duty_ready <= ($urandom_range(99, 0) >= stall_pct);

	// counts cycles with no word moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (duty_valid && duty_ready)
			|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// channel order: far left, inner left, middle, inner right, far right
	task automatic send_coils(input int rfl, input int ril, input int rm, input int rir,
		input int rfr, input int afl, input int ail, input int am, input int air,
		input int afr);
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		raw_far_left    <= SB'(rfl);
		raw_inner_left  <= SB'(ril);
		raw_middle      <= SB'(rm);
		raw_inner_right <= SB'(rir);
		raw_far_right   <= SB'(rfr);
		avg_far_left    <= SB'(afl);
		avg_inner_left  <= SB'(ail);
		avg_middle      <= SB'(am);
		avg_inner_right <= SB'(air);
		avg_far_right   <= SB'(afr);
		sample_valid    <= 1'b1;
		do begin
			@(posedge clk);
		end while (!sample_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
	endtask

	task automatic apply_settings(input int base, input int kp, input int kd, input int thr,
		input int lost, input int limit, input int dfloor);
		write_reg(CFG_BASE_SPEED, base);
		write_reg(CFG_KP_GAIN, kp);
		write_reg(CFG_KD_GAIN, kd);
		write_reg(CFG_TURN_THRESHOLD, thr);
		write_reg(CFG_LOST_THRESHOLD, lost);
		write_reg(CFG_DUTY_LIMIT, limit);
		write_reg(CFG_DUTY_FLOOR, dfloor);
		@(negedge clk);
		cfg_valid <= 1'b0;
		turn_thr = thr;
		lost_thr = lost;
	endtask

	task automatic settle(input int tail);
		@(negedge clk);
		sample_valid <= 1'b0;
		while (owed != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// mostly below the reset peak so normalization keeps varying
	function automatic int pick_raw(input int lo);
		if (lo > 2999 || $urandom_range(99, 0) < 3)
			return $urandom_range(4095, lo);
		return $urandom_range(2999, lo);
	endfunction

	function automatic int pick_avg(input int other);
		int r, v;
		r = $urandom_range(99, 0);
		if (r < 10)
			return 0;
		if (r < 15)
			return 4095;
		if (r < 35) begin
			// nearly balanced pair: small error
			v = other + $urandom_range(60, 0) - 30;
			return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
		end
		return $urandom_range(4095, 0);
	endfunction

	task automatic send_random();
		int kind, ril, rir, rm, lo, lim, afl, afr, ail, air;
		kind = $urandom_range(99, 0);
		if (kind >= 95) begin
			send_coils($urandom_range(4095, 0), $urandom_range(4095, 0),
				$urandom_range(4095, 0), $urandom_range(4095, 0), $urandom_range(4095, 0),
				$urandom_range(4095, 0), $urandom_range(4095, 0), $urandom_range(4095, 0),
				$urandom_range(4095, 0), $urandom_range(4095, 0));
		end else begin
			if (kind < 40) begin
				lo = (turn_thr + 1) / 2;
				if (lo > 4095)
					lo = 4095;
				ril = pick_raw(lo);
				rir = pick_raw(lo);
			end else begin
				lim = (turn_thr == 0) ? 0 : (turn_thr - 1) / 2;
				if (lim > 2999)
					lim = 2999;
				ril = $urandom_range(lim, 0);
				rir = $urandom_range(lim, 0);
			end
			if (kind < 80)
				rm = $urandom_range(4095, lost_thr);
			else
				rm = (lost_thr == 0) ? 0 : $urandom_range(lost_thr - 1, 0);
			afl = pick_avg($urandom_range(4095, 0));
			afr = pick_avg(afl);
			ail = pick_avg($urandom_range(4095, 0));
			air = pick_avg(ail);
			send_coils(pick_raw(0), ril, rm, rir, pick_raw(0),
				afl, ail, $urandom_range(4095, 0), air, afr);
		end
	endtask

	initial begin : drive_stimulus
		int base, limit;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				settle(4);
			case (p)
				0: ;
				1: begin
					write_reg(CFG_SPARE, $urandom_range(65535, 0));
					apply_settings(0, 0, 0, 0, 0, 0, 0);
				end
				2: apply_settings(65535, 4095, 4095, 8191, 4095, 65535, 65535);
				3: apply_settings(BASE_SPEED_RST, KP_GAIN_RST, KD_GAIN_RST, TURN_THR_RST,
					LOST_THR_RST, DUTY_LIMIT_RST, DUTY_FLOOR_RST);
				4: apply_settings(65535, 4095, 4095, 0, 0, 65535, 0);
				default: begin
					base = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
						: $urandom_range(9000, 0);
					limit = ($urandom_range(3, 0) == 0) ? $urandom_range(65535, 0)
						: $urandom_range(12000, 2000);
					apply_settings(base, $urandom_range(4095, 0), $urandom_range(4095, 0),
						$urandom_range(1, 0) ? $urandom_range(2000, 0) : $urandom_range(8191, 0),
						$urandom_range(7, 0) ? $urandom_range(800, 0) : $urandom_range(4095, 0),
						limit,
						$urandom_range(3, 0) ? $urandom_range(limit / 2, 0)
						: $urandom_range(65535, 0));
				end
			endcase
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			if (p == 0) begin
				// reset settings, all peaks still at 3000
				send_coils(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
				send_coils(1000, 100, 1000, 100, 1000, 1500, 1500, 1500, 1500, 1500);
				send_coils(1000, 100, 1000, 100, 1000, 0, 800, 1500, 800, 4095);
				send_coils(1000, 100, 1000, 100, 1000, 4095, 800, 1500, 800, 0);
				send_coils(1000, 100, 1000, 100, 1000, 1500, 800, 1500, 800, 1700);
				send_coils(1000, 100, 1000, 100, 1000, 1500, 800, 1500, 800, 1000);
				send_coils(800, 300, 900, 300, 800, 800, 500, 900, 3000, 800);
				send_coils(800, 300, 900, 300, 800, 800, 3000, 900, 500, 800);
				send_coils(800, 300, 900, 300, 800, 800, 2000, 900, 2000, 800);
				send_coils(800, 300, 900, 300, 800, 800, 0, 900, 0, 800);
				// inner sum right at the turn threshold, then one below
				send_coils(800, 250, 900, 250, 800, 600, 100, 900, 4095, 900);
				send_coils(800, 250, 900, 249, 800, 600, 100, 900, 4095, 900);
				// middle right at the lost threshold, then one below
				send_coils(800, 100, 50, 100, 800, 2000, 0, 0, 0, 2400);
				send_coils(800, 100, 49, 100, 800, 2000, 0, 0, 0, 2400);
				send_coils(800, 100, 10, 100, 800, 4095, 0, 0, 0, 0);
				send_coils(800, 100, 600, 100, 800, 4095, 0, 0, 0, 0);
				send_coils(800, 100, 600, 100, 800, 4095, 4095, 4095, 4095, 4095);
				send_coils(3500, 100, 600, 100, 2000, 3500, 0, 0, 0, 2000);
			end
			repeat (PHASE_ITEMS) send_random();
		end
		settle(DRAIN_CYCLES);
		if (fail_count == 0 && owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== line_follow_pd_steering.f =====
src/lfps_pkg.sv
src/lfps_div.sv
src/lfps_pdmul.sv
src/line_follow_pd_steering.sv
sim/duty_checker.sv
sim/tb_top.sv
